### design/ljat_pkg.sv
package ljat_pkg;

    // Species count and per-pair table geometry.
    localparam int NUM_SPECIES = 4;
    localparam int TBL_DEPTH   = NUM_SPECIES * NUM_SPECIES;
    localparam int TBL_AW      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // Request and response field widths.
    localparam int VAL_W    = 32;
    localparam int Q_W      = 48;
    localparam int ENERGY_W = 48;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Request opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Load targets.
    localparam logic [2:0] PSEL_SIGMA   = 3'd0;
    localparam logic [2:0] PSEL_EPSILON = 3'd1;
    localparam logic [2:0] PSEL_CUTOFF  = 3'd2;
    localparam logic [2:0] PSEL_MIN_RAD = 3'd3;
    localparam logic [2:0] PSEL_ZERO_RAD = 3'd4;

    // Core radius modes.
    localparam logic [1:0] CRM_SIGMA      = 2'd0;
    localparam logic [1:0] CRM_MIN        = 2'd1;
    localparam logic [1:0] CRM_ZERO       = 2'd2;
    localparam logic [1:0] CRM_SIG_TO_MIN = 2'd3;

    // Register index, taken from address bit 2.
    localparam logic REG_CRM = 1'b0;
    localparam logic REG_CCM = 1'b1;

    // Saturation limit of the Q.32 ratios and powers, and of the energy magnitude.
    localparam logic [Q_W-1:0] CAPQ = 48'h8000_0000_0000;

    // Divider and multiplier pipeline shape.
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = Q_W / DIV_STEP;
    localparam int MUL_LAT    = 2;

    // Queue between the front and back halves.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic             op;
        logic [1:0]       pair_i;
        logic [1:0]       pair_j;
        logic [2:0]       param_sel;
        logic [VAL_W-1:0] param_value;
        logic [VAL_W-1:0] distance;
    } req_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy;
        logic                       saturated;
    } rsp_t;

    // Classified work handed from the front to the back.
    typedef struct packed {
        logic             compute;
        logic [VAL_W-1:0] sig;
        logic [VAL_W-1:0] eps;
        logic [VAL_W-1:0] cut;
        logic [VAL_W-1:0] r_eff;
    } job_t;

    // Round half up from Q.64 to Q.32 and saturate at CAPQ.
    function automatic logic [Q_W-1:0] round_q32_sat47(input logic [127:0] p);
        logic [127:0] r;
        logic [95:0]  v;
        r = p + 128'h8000_0000;
        v = r[127:32];
        if (v > {48'd0, CAPQ})
            round_q32_sat47 = CAPQ;
        else
            round_q32_sat47 = v[Q_W-1:0];
    endfunction

    // Round half up from Q.64 to Q.32 and saturate at 64 bits.
    function automatic logic [63:0] round_q32_sat64(input logic [127:0] p);
        logic [127:0] r;
        logic [95:0]  v;
        r = p + 128'h8000_0000;
        v = r[127:32];
        if (v[95:64] != 32'd0)
            round_q32_sat64 = {64{1'b1}};
        else
            round_q32_sat64 = v[63:0];
    endfunction

endpackage

### design/ljat_front.sv
module ljat_front (
    input  logic              clk,
    input  ljat_pkg::req_t    req,
    input  logic              req_accept,
    input  logic [1:0]        core_radius_mode,
    input  logic              core_const_mode,
    output ljat_pkg::job_t    job
);

    logic [ljat_pkg::VAL_W-1:0] sigma_table     [ljat_pkg::TBL_DEPTH];
    logic [ljat_pkg::VAL_W-1:0] epsilon_table   [ljat_pkg::TBL_DEPTH];
    logic [ljat_pkg::VAL_W-1:0] cutoff_table    [ljat_pkg::TBL_DEPTH];
    logic [ljat_pkg::VAL_W-1:0] min_radius_table [ljat_pkg::TBL_DEPTH];
    logic [ljat_pkg::VAL_W-1:0] zero_radius_table [ljat_pkg::TBL_DEPTH];

    logic [7:0]                  idx_wide;
    logic [ljat_pkg::TBL_AW-1:0] idx;
    logic                        in_range;
    logic [ljat_pkg::VAL_W-1:0]  sig;
    logic [ljat_pkg::VAL_W-1:0]  eps;
    logic [ljat_pkg::VAL_W-1:0]  cut;
    logic [ljat_pkg::VAL_W-1:0]  rmin;
    logic [ljat_pkg::VAL_W-1:0]  r;
    logic                        zero_core;

    // Table entry of the species pair.
    assign in_range = ({6'd0, req.pair_i} < 8'(ljat_pkg::NUM_SPECIES)) &&
                      ({6'd0, req.pair_j} < 8'(ljat_pkg::NUM_SPECIES));
    assign idx_wide = 8'({6'd0, req.pair_i} * 8'(ljat_pkg::NUM_SPECIES)) + {6'd0, req.pair_j};
    assign idx      = idx_wide[ljat_pkg::TBL_AW-1:0];

    // Load requests write one parameter of one pair.
    always_ff @(posedge clk)
    begin
        if (req_accept && req.op == ljat_pkg::OP_LOAD && in_range)
        begin
            case (req.param_sel)
                ljat_pkg::PSEL_SIGMA:    sigma_table[idx]       <= req.param_value;
                ljat_pkg::PSEL_EPSILON:  epsilon_table[idx]     <= req.param_value;
                ljat_pkg::PSEL_CUTOFF:   cutoff_table[idx]      <= req.param_value;
                ljat_pkg::PSEL_MIN_RAD:  min_radius_table[idx]  <= req.param_value;
                ljat_pkg::PSEL_ZERO_RAD: zero_radius_table[idx] <= req.param_value;
                default: ;
            endcase
        end
    end

    // Core radius selection.
    always_comb
    begin
        sig = sigma_table[idx];
        eps = epsilon_table[idx];
        cut = cutoff_table[idx];
        r   = req.distance;
        case (core_radius_mode)
            ljat_pkg::CRM_SIGMA: rmin = sig;
            ljat_pkg::CRM_ZERO:  rmin = zero_radius_table[idx];
            default:             rmin = min_radius_table[idx];
        endcase
    end

    // Classification: a bad pair, a non-eval op, r beyond the cutoff, r in
    // the core with core_const_mode, or r < sigma in CRM_SIG_TO_MIN: energy 0.
    always_comb
    begin
        zero_core = ((r < rmin) && core_const_mode) ||
                    ((r < sig) && (core_radius_mode == ljat_pkg::CRM_SIG_TO_MIN));
        job.compute = (req.op == ljat_pkg::OP_EVAL) && in_range && !zero_core && (r <= cut);
        job.sig     = sig;
        job.eps     = eps;
        job.cut     = cut;
        job.r_eff   = (r < rmin) ? rmin : r;
    end

endmodule

### design/ljat_fifo.sv
module ljat_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ljat_pkg::job_t din,
    output logic           full,
    input  logic           pop,
    output ljat_pkg::job_t dout,
    output logic           not_empty
);

    ljat_pkg::job_t               mem_reg [ljat_pkg::FIFO_DEPTH];
    logic [ljat_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [ljat_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [ljat_pkg::FIFO_AW:0]   count_reg;
    logic [ljat_pkg::FIFO_AW:0]   count_next;

    assign full      = (count_reg == (ljat_pkg::FIFO_AW + 1)'(ljat_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

### design/ljat_div.sv
module ljat_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ljat_pkg::VAL_W-1:0] num,
    input  logic [ljat_pkg::VAL_W-1:0] den,
    output logic [ljat_pkg::Q_W-1:0]   quo
);

    typedef struct packed {
        logic [31:0]              rem;
        logic [31:0]              den;
        logic [ljat_pkg::Q_W-1:0] dvd;
        logic [ljat_pkg::Q_W-1:0] q;
        logic                     ovf;
    } stage_t;

    // DIV_STEP restoring division steps, one quotient bit each.
    function automatic stage_t div_step(input stage_t s);
        stage_t      o;
        logic [32:0] tmp;
        logic [32:0] diff;
        o = s;
        for (int b = 0; b < ljat_pkg::DIV_STEP; b++)
        begin
            tmp   = {o.rem, o.dvd[ljat_pkg::Q_W-1]};
            o.dvd = {o.dvd[ljat_pkg::Q_W-2:0], 1'b0};
            diff  = tmp - {1'b0, o.den};
            if (tmp >= {1'b0, o.den})
            begin
                o.rem = diff[31:0];
                o.q   = {o.q[ljat_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = tmp[31:0];
                o.q   = {o.q[ljat_pkg::Q_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    stage_t st_reg  [ljat_pkg::DIV_STAGES];
    stage_t st_next [ljat_pkg::DIV_STAGES];
    stage_t init;
    stage_t last;

    // The top 16 quotient bits are nonzero exactly when num >> 16 reaches den;
    // the quotient then exceeds the cap, as it does for a zero divisor.
    always_comb
    begin
        init.rem = {16'd0, num[31:16]};
        init.den = den;
        init.dvd = {num[15:0], 32'd0};
        init.q   = '0;
        init.ovf = (den == 32'd0) || ({16'd0, num[31:16]} >= den);
        st_next[0] = div_step(init);
        for (int k = 1; k < ljat_pkg::DIV_STAGES; k++)
            st_next[k] = div_step(st_reg[k-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ljat_pkg::DIV_STAGES; k++)
                st_reg[k] <= st_next[k];
        end
    end

    // Saturate the quotient at the cap.
    assign last = st_reg[ljat_pkg::DIV_STAGES-1];
    assign quo  = (last.ovf || (last.q > ljat_pkg::CAPQ)) ? ljat_pkg::CAPQ : last.q;

endmodule

### design/ljat_mul.sv
module ljat_mul (
    input  logic          clk,
    input  logic          en,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic [127:0]  p
);

    logic [63:0]  ll_reg;
    logic [63:0]  lh_reg;
    logic [63:0]  hl_reg;
    logic [63:0]  hh_reg;
    logic [127:0] p_reg;

    // First stage: four 32 by 32 partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
            lh_reg <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
            hl_reg <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
            hh_reg <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
        end
    end

    // Second stage: align and sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= {64'd0, ll_reg} + {32'd0, lh_reg, 32'd0} +
                     {32'd0, hl_reg, 32'd0} + {hh_reg, 64'd0};
        end
    end

    assign p = p_reg;

endmodule

### design/ljat_back.sv
module ljat_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  ljat_pkg::job_t job,
    output logic           pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ljat_pkg::rsp_t rsp
);

    localparam int D       = ljat_pkg::DIV_STAGES;
    localparam int ML      = ljat_pkg::MUL_LAT;
    localparam int SB_LEN  = D + 5 * ML + 5;
    localparam int CMP_TAP = D + 3 * (ML + 1) - 1;
    localparam int EPS_TAP = D + 4 * (ML + 1);

    logic                       adv;
    logic [SB_LEN-1:0]          vld_reg;
    logic                       cmp_reg [SB_LEN];
    logic [ljat_pkg::VAL_W-1:0] eps_reg [SB_LEN];

    logic [ljat_pkg::Q_W-1:0] s_q;
    logic [ljat_pkg::Q_W-1:0] t_q;
    logic [127:0]             ps2;
    logic [127:0]             pt2;
    logic [127:0]             ps4;
    logic [127:0]             pt4;
    logic [127:0]             px;
    logic [127:0]             py;
    logic [127:0]             pm;
    logic [127:0]             pmag;

    logic [ljat_pkg::Q_W-1:0] s2_reg;
    logic [ljat_pkg::Q_W-1:0] t2_reg;
    logic [ljat_pkg::Q_W-1:0] s2d_reg [ML+1];
    logic [ljat_pkg::Q_W-1:0] t2d_reg [ML+1];
    logic [ljat_pkg::Q_W-1:0] s4_reg;
    logic [ljat_pkg::Q_W-1:0] t4_reg;
    logic [ljat_pkg::Q_W-1:0] x_reg;
    logic [ljat_pkg::Q_W-1:0] y_reg;

    logic                     aneg;
    logic                     eneg;
    logic [ljat_pkg::Q_W-1:0] am;
    logic [ljat_pkg::Q_W:0]   xy_sum;
    logic [ljat_pkg::Q_W:0]   em;
    logic                     bracket_neg;
    logic [ljat_pkg::Q_W-1:0] am_reg;
    logic [ljat_pkg::Q_W:0]   em_reg;
    logic [63:0]              m_reg;

    logic [127:0]             mag_rnd;
    logic [105:0]             mag_full;
    logic [ljat_pkg::Q_W-1:0] mag;
    logic                     mag_sat;

    logic           rsp_valid_reg;
    ljat_pkg::rsp_t rsp_reg;
    ljat_pkg::rsp_t rsp_next;

    // The whole pipeline moves whenever the output register can take a value.
    assign adv = !rsp_valid_reg || !rsp_stall;
    assign pop = adv && job_valid;

    // Valid bits along the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[SB_LEN-2:0], job_valid};
    end

    // Side data that travels alongside the arithmetic.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmp_reg[0] <= job.compute;
            eps_reg[0] <= job.eps;
            for (int k = 1; k < SB_LEN; k++)
            begin
                cmp_reg[k] <= cmp_reg[k-1];
                eps_reg[k] <= eps_reg[k-1];
            end
        end
    end

    // Ratios s = sigma / r and t = sigma / cutoff in Q.32.
    ljat_div u_div_s (.clk(clk), .en(adv), .num(job.sig), .den(job.r_eff), .quo(s_q));
    ljat_div u_div_t (.clk(clk), .en(adv), .num(job.sig), .den(job.cut), .quo(t_q));

    // Squares.
    ljat_mul u_mul_s2 (.clk(clk), .en(adv), .a({16'd0, s_q}), .b({16'd0, s_q}), .p(ps2));
    ljat_mul u_mul_t2 (.clk(clk), .en(adv), .a({16'd0, t_q}), .b({16'd0, t_q}), .p(pt2));

    // Fourth powers.
    ljat_mul u_mul_s4 (.clk(clk), .en(adv), .a({16'd0, s2_reg}), .b({16'd0, s2_reg}),
                       .p(ps4));
    ljat_mul u_mul_t4 (.clk(clk), .en(adv), .a({16'd0, t2_reg}), .b({16'd0, t2_reg}),
                       .p(pt4));

    // Sixth powers from the fourth power and the delayed square.
    ljat_mul u_mul_x (.clk(clk), .en(adv), .a({16'd0, s4_reg}), .b({16'd0, s2d_reg[ML]}),
                      .p(px));
    ljat_mul u_mul_y (.clk(clk), .en(adv), .a({16'd0, t4_reg}), .b({16'd0, t2d_reg[ML]}),
                      .p(py));

    // Rounded, saturated power registers and the square delay lines.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg     <= ljat_pkg::round_q32_sat47(ps2);
            t2_reg     <= ljat_pkg::round_q32_sat47(pt2);
            s2d_reg[0] <= s2_reg;
            t2d_reg[0] <= t2_reg;
            for (int k = 1; k <= ML; k++)
            begin
                s2d_reg[k] <= s2d_reg[k-1];
                t2d_reg[k] <= t2d_reg[k-1];
            end
            s4_reg <= ljat_pkg::round_q32_sat47(ps4);
            t4_reg <= ljat_pkg::round_q32_sat47(pt4);
            x_reg  <= ljat_pkg::round_q32_sat47(px);
            y_reg  <= ljat_pkg::round_q32_sat47(py);
        end
    end

    // Bracket factors a = x - y and e = x + y - 1 as sign and magnitude. A
    // bracket that is not negative, or a zero-energy request, forces |a| to
    // zero so the product chain yields zero.
    always_comb
    begin
        aneg   = x_reg < y_reg;
        am     = aneg ? (y_reg - x_reg) : (x_reg - y_reg);
        xy_sum = {1'b0, x_reg} + {1'b0, y_reg};
        eneg   = xy_sum < 49'h1_0000_0000;
        em     = eneg ? (49'h1_0000_0000 - xy_sum) : (xy_sum - 49'h1_0000_0000);
        bracket_neg = cmp_reg[CMP_TAP] && (am != '0) && (em != '0) && (aneg != eneg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            am_reg <= bracket_neg ? am : '0;
            em_reg <= em;
            m_reg  <= ljat_pkg::round_q32_sat64(pm);
        end
    end

    // m = |a| * |e| in Q.32, then 4 * eps * m.
    ljat_mul u_mul_m (.clk(clk), .en(adv), .a({16'd0, am_reg}), .b({15'd0, em_reg}),
                      .p(pm));
    ljat_mul u_mul_mag (.clk(clk), .en(adv), .a(m_reg), .b({32'd0, eps_reg[EPS_TAP]}),
                        .p(pmag));

    // Final rounding, saturation and negation.
    always_comb
    begin
        mag_rnd  = pmag + 128'h20_0000;
        mag_full = mag_rnd[127:22];
        mag_sat  = mag_full > {58'd0, ljat_pkg::CAPQ};
        mag      = mag_sat ? ljat_pkg::CAPQ : mag_full[ljat_pkg::Q_W-1:0];
        rsp_next.energy    = $signed(~mag + 48'd1);
        rsp_next.saturated = mag_sat;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= vld_reg[SB_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### design/lj_attractive_tail_cut_shifted.sv
// Throughput: one request per cycle while rsp_stall is low; the 16-stage dividers
// and the chain of two-stage multipliers are fully pipelined behind a four-entry queue.
// Reset: core_radius_mode clears to 0 and core_const_mode to 1; the pipeline and
// queue empty. Parameter tables are not cleared and hold nothing until loaded.
module lj_attractive_tail_cut_shifted (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  ljat_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output ljat_pkg::rsp_t               rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ljat_pkg::PADDR_W-1:0] paddr,
    input  logic [ljat_pkg::PDATA_W-1:0] pwdata,
    output logic [ljat_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic [1:0]     crm_reg;
    logic           ccm_reg;
    logic           cfg_write;
    logic           req_accept;
    logic           fifo_full;
    logic           fifo_not_empty;
    logic           fifo_pop;
    ljat_pkg::job_t front_job;
    ljat_pkg::job_t back_job;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crm_reg <= ljat_pkg::CRM_SIGMA;
            ccm_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ljat_pkg::REG_CRM)
                crm_reg <= pwdata[1:0];
            else
                ccm_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == ljat_pkg::REG_CCM) ? {31'd0, ccm_reg} : {30'd0, crm_reg};

    // A request is taken whenever the queue has room.
    assign req_stall  = fifo_full;
    assign req_accept = req_valid && !fifo_full;

    ljat_front u_front (
        .clk              (clk),
        .req              (req),
        .req_accept       (req_accept),
        .core_radius_mode (crm_reg),
        .core_const_mode  (ccm_reg),
        .job              (front_job)
    );

    ljat_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_accept),
        .din       (front_job),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .dout      (back_job),
        .not_empty (fifo_not_empty)
    );

    ljat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (fifo_not_empty),
        .job       (back_job),
        .pop       (fifo_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
